>>> rtl/octahedron_face_normals_macros.svh
// Assertion macros shared by the face normal block.
`ifndef OCTAHEDRON_FACE_NORMALS_MACROS_SVH
`define OCTAHEDRON_FACE_NORMALS_MACROS_SVH
`ifndef SYNTH
`define OFN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OFN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OFN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OFN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ofn_pkg.sv
// Package with shared constants and types of the face normal block.
package ofn_pkg;
    localparam int NUM_VERTICES = 6;
    localparam int NUM_FACES    = 4;
    localparam int CW  = 32;
    localparam int EW  = 33;
    localparam int PW  = 66;
    localparam int XW  = 67;

    typedef enum logic [1:0] {
        t_OP_IDLE = 2'd0,
        t_OP_SQRT = 2'd1,
        t_OP_DIV  = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] num;
        logic [31:0] den;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_alu_rsp;
endpackage

>>> rtl/ofn_ram.sv
// Generic single write, single registered read RAM.
module ofn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/ofn_alu.sv
// Shared bit serial square root and divide unit.
module ofn_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ofn_pkg::t_alu_req i_req,
    output ofn_pkg::t_alu_rsp o_rsp
);
    // Square root: restoring two bits a step over 64 bit radicand.
    // Divide: restoring one bit a step, 64 bit numerator, 32 bit divisor.
    logic [63:0] r_num, n_num;
    logic [65:0] r_rem, n_rem;
    logic [63:0] r_res, n_res;
    logic [31:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_div, n_div;
    logic        r_done, n_done;
    logic [65:0] w_trial;
    logic [65:0] w_shrem;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_res  = r_res;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_div  = r_div;
        n_done = 1'b0;
        w_shrem = '0;
        w_trial = '0;
        if (i_req.start) begin
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_div  = i_req.is_div;
            n_rem  = '0;
            n_res  = '0;
            n_cnt  = i_req.is_div ? 7'd64 : 7'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_div) begin
                w_shrem = {r_rem[64:0], r_num[63]};
                w_trial = w_shrem - {34'd0, r_den};
                n_num   = {r_num[62:0], 1'b0};
                if (!w_trial[65]) begin
                    n_rem = w_trial;
                    n_res = {r_res[62:0], 1'b1};
                end else begin
                    n_rem = w_shrem;
                    n_res = {r_res[62:0], 1'b0};
                end
            end else begin
                w_shrem = {r_rem[63:0], r_num[63:62]};
                w_trial = w_shrem - {r_res[63:0], 2'b01};
                n_num   = {r_num[61:0], 2'b00};
                if (!w_trial[65]) begin
                    n_rem = w_trial;
                    n_res = {r_res[62:0], 1'b1};
                end else begin
                    n_rem = w_shrem;
                    n_res = {r_res[62:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_res <= n_res;
        r_den <= n_den;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

>>> rtl/octahedron_face_normals.sv
// Top level of the octahedron face normal unit.
//
//  channel  | direction | fields
//  ---------+-----------+---------------------------------------------------
//  vertex   | in        | vertex_index, vertex_x/y/z, final_vertex
//  normal   | out       | face_index, normal_x/y/z, degenerate, last_face
//
// A vertex beat that is not final is stored. A final beat starts the face sequencer:
// each face reads its vertices, settles, forms the cross product, normalises, runs the
// 32 step square root and three 64 step divides, then emits and waits; a degenerate
// face skips the square root and divides. Reset is synchronous and active low; the
// vertex store is not cleared. The input is stalled while faces are computed, and an
// output stall holds the normal register and keeps the sequencer waiting in its emit state.
module octahedron_face_normals #(
    parameter int NUM_VERTICES = ofn_pkg::NUM_VERTICES,
    parameter int NUM_FACES    = ofn_pkg::NUM_FACES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_vertex_index,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_vertex_z,
    input  logic        i_final_vertex,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_face_index,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z,
    output logic        o_degenerate,
    output logic        o_last_face
);
`include "octahedron_face_normals_macros.svh"
    localparam int AW = $clog2(NUM_VERTICES);

    typedef enum logic [9:0] {
        t_IDLE  = 10'b0000000001,
        t_RDA   = 10'b0000000010,
        t_RDB   = 10'b0000000100,
        t_CROSS = 10'b0000001000,
        t_NORM  = 10'b0000010000,
        t_SQRT  = 10'b0000100000,
        t_DIV   = 10'b0001000000,
        t_EMIT  = 10'b0010000000,
        t_WAIT  = 10'b0100000000,
        t_LOADV = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_face, n_face;
    logic [2:0] r_step, n_step;   // sub step counter inside a state
    logic       w_in_acc, w_out_acc;

    // Vertex store: three small RAMs, read one vertex a cycle.
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rx, w_ry, w_rz;
    logic          w_we;
    assign w_in_acc = i_valid && !o_stall;
    assign w_we     = w_in_acc && (i_vertex_index < 3'(NUM_VERTICES));

    ofn_ram #(.WIDTH(32), .DEPTH(NUM_VERTICES)) u_ram_x (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(i_vertex_index[AW-1:0]), .i_wdata(i_vertex_x), .i_raddr(w_raddr),
        .o_rdata(w_rx));
    ofn_ram #(.WIDTH(32), .DEPTH(NUM_VERTICES)) u_ram_y (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(i_vertex_index[AW-1:0]), .i_wdata(i_vertex_y), .i_raddr(w_raddr),
        .o_rdata(w_ry));
    ofn_ram #(.WIDTH(32), .DEPTH(NUM_VERTICES)) u_ram_z (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(i_vertex_index[AW-1:0]), .i_wdata(i_vertex_z), .i_raddr(w_raddr),
        .o_rdata(w_rz));

    // Face f uses origin o, a-end and b-end: a = va - vo, b = vb - vo.
    logic [2:0] w_vo, w_va, w_vb;
    always_comb begin
        unique case (r_face)
            2'd0:    begin w_vo = 3'd0; w_va = 3'd1; w_vb = 3'd4; end
            2'd1:    begin w_vo = 3'd0; w_va = 3'd3; w_vb = 3'd4; end
            2'd2:    begin w_vo = 3'd2; w_va = 3'd1; w_vb = 3'd4; end
            default: begin w_vo = 3'd2; w_va = 3'd3; w_vb = 3'd4; end
        endcase
    end

    // Origin vertex held, then edges built from following reads.
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic signed [32:0] r_a [3];
    logic signed [32:0] r_b [3];
    logic signed [66:0] r_c [3];
    logic signed [65:0] r_p0;
    logic [65:0] r_mag [3];
    logic [2:0]  r_neg;
    logic [31:0] r_m [3];
    logic [63:0] r_sum;
    logic [31:0] r_len;
    logic [31:0] r_q [3];
    logic [6:0]  r_maxl;

    always_comb begin
        unique case (r_step)
            3'd0:    w_raddr = w_vo[AW-1:0];
            3'd1:    w_raddr = w_va[AW-1:0];
            default: w_raddr = w_vb[AW-1:0];
        endcase
    end

    // One 33x33 multiplier, shared over the six cross product terms.
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic [1:0] w_ci;
    always_comb begin
        // step 0..5: component i = step>>1; even step first term, odd second
        w_ci = r_step[2:1];
        unique case (w_ci)
            2'd0: begin
                w_ma = r_step[0] ? r_a[2] : r_a[1];
                w_mb = r_step[0] ? r_b[1] : r_b[2];
            end
            2'd1: begin
                w_ma = r_step[0] ? r_a[0] : r_a[2];
                w_mb = r_step[0] ? r_b[2] : r_b[0];
            end
            default: begin
                w_ma = r_step[0] ? r_a[1] : r_a[0];
                w_mb = r_step[0] ? r_b[0] : r_b[1];
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Bit length of a 66 bit magnitude.
    function automatic logic [6:0] bitlen(input logic [65:0] v);
        logic [6:0] n;
        n = '0;
        for (int k = 0; k < 66; k++) begin
            if (v[k]) n = 7'(k + 1);
        end
        return n;
    endfunction

    // Shifter normalising one magnitude so the largest has 31 bits.
    logic [65:0] w_shv;
    logic [31:0] w_msh;
    always_comb begin
        w_shv = r_mag[r_step[1:0]];
        if (r_maxl > 7'd31) w_msh = 32'(w_shv >> (r_maxl - 7'd31));
        else                w_msh = 32'(w_shv << (7'd31 - r_maxl));
    end

    // Sum of squares, one square per step from its own multiplier.
    // Each square is taken in the step after the shift of its magnitude.
    logic [1:0]  w_sqi;
    logic [63:0] w_sq;
    assign w_sqi = r_step[1:0] - 2'd1;
    assign w_sq  = r_m[w_sqi] * r_m[w_sqi];

    // Shared iterative unit.
    ofn_pkg::t_alu_req w_req;
    ofn_pkg::t_alu_rsp w_rsp;
    ofn_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic r_started, n_started;
    always_comb begin
        w_req.start  = 1'b0;
        w_req.is_div = 1'b0;
        w_req.num    = r_sum;
        w_req.den    = r_len;
        if (r_state == t_SQRT && !r_started) begin
            w_req.start = 1'b1;
        end else if (r_state == t_DIV && !r_started) begin
            w_req.start  = 1'b1;
            w_req.is_div = 1'b1;
            w_req.num    = {2'b00, r_m[r_step[1:0]], 30'd0} + {33'd0, r_len[31:1]};
        end
    end

    // Output register. It parts the two channels, so a waiting normal does not hold
    // off vertex beats while the sequencer is idle.
    logic r_ovalid;
    assign o_stall   = (r_state != t_IDLE);
    assign w_out_acc = r_ovalid && !i_stall;
    assign o_valid   = r_ovalid;

    always_comb begin
        n_state   = r_state;
        n_face    = r_face;
        n_step    = r_step;
        n_started = r_started;
        unique case (r_state)
            t_IDLE: if (w_in_acc && i_final_vertex) begin
                n_state = t_LOADV;
                n_face  = '0;
                n_step  = '0;
            end
            t_LOADV: begin
                // Issue reads of origin, a and b in turn and capture the returned data.
                n_step = r_step + 3'd1;
                if (r_step == 3'd3) begin
                    n_state = t_RDA;
                    n_step  = '0;
                end
            end
            t_RDA: begin
                n_state = t_CROSS;
            end
            t_RDB: begin
                n_state = t_CROSS;
            end
            t_CROSS: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = t_NORM;
                    n_step  = '0;
                end
            end
            t_NORM: begin
                // step 0 magnitudes, 1..3 sizes, 4..6 shift, 5..7 squares
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_step  = '0;
                    n_state = (r_maxl == 7'd0) ? t_EMIT : t_SQRT;
                end
            end
            t_SQRT: begin
                n_started = 1'b1;
                if (w_rsp.done) begin
                    n_started = 1'b0;
                    n_state   = t_DIV;
                    n_step    = '0;
                end
            end
            t_DIV: begin
                n_started = 1'b1;
                if (w_rsp.done) begin
                    n_started = 1'b0;
                    n_step    = r_step + 3'd1;
                    if (r_step == 3'd2) begin
                        n_state = t_EMIT;
                        n_step  = '0;
                    end
                end
            end
            t_EMIT: begin
                if (!r_ovalid || w_out_acc) n_state = t_WAIT;
            end
            t_WAIT: begin
                if (r_face == 2'(NUM_FACES - 1)) begin
                    n_state = t_IDLE;
                end else begin
                    n_face  = r_face + 2'd1;
                    n_state = t_LOADV;
                end
            end
            default: n_state = t_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= t_IDLE;
            r_face    <= '0;
            r_step    <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_face    <= n_face;
            r_step    <= n_step;
            r_started <= n_started;
            if (r_state == t_EMIT && (!r_ovalid || w_out_acc)) r_ovalid <= 1'b1;
            else if (w_out_acc) r_ovalid <= 1'b0;
        end
        // Edge capture: read data arrives in the cycle after its address.
        if (r_state == t_LOADV) begin
            unique case (r_step)
                3'd1: begin r_ox <= w_rx; r_oy <= w_ry; r_oz <= w_rz; end
                3'd2: begin
                    r_a[0] <= 33'($signed(w_rx)) - 33'(r_ox);
                    r_a[1] <= 33'($signed(w_ry)) - 33'(r_oy);
                    r_a[2] <= 33'($signed(w_rz)) - 33'(r_oz);
                end
                3'd3: begin
                    r_b[0] <= 33'($signed(w_rx)) - 33'(r_ox);
                    r_b[1] <= 33'($signed(w_ry)) - 33'(r_oy);
                    r_b[2] <= 33'($signed(w_rz)) - 33'(r_oz);
                end
                default: ;
            endcase
        end
        if (r_state == t_CROSS) begin
            if (!r_step[0]) r_p0 <= w_prod;
            else            r_c[w_ci] <= 67'(r_p0) - 67'(w_prod);
        end
        if (r_state == t_NORM) begin
            if (r_step == 3'd0) begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= r_c[k][66];
                    r_mag[k] <= r_c[k][66] ? 66'(-r_c[k]) : 66'(r_c[k]);
                end
                r_maxl <= '0;
                r_sum  <= '0;
            end else if (r_step <= 3'd3) begin
                if (bitlen(r_mag[r_step[1:0] - 2'd1]) > r_maxl)
                    r_maxl <= bitlen(r_mag[r_step[1:0] - 2'd1]);
            end else begin
                if (r_step != 3'd7) r_m[r_step[1:0]] <= w_msh;
                if (r_step != 3'd4) r_sum <= r_sum + w_sq;
            end
        end
        if (r_state == t_SQRT) begin
            if (!r_started) r_sum <= r_sum;
            if (w_rsp.done) r_len <= w_rsp.res[31:0];
        end
        if (r_state == t_DIV && w_rsp.done) r_q[r_step[1:0]] <= w_rsp.res[31:0];
        if (r_state == t_EMIT && (!r_ovalid || w_out_acc)) begin
            o_face_index <= r_face;
            o_last_face  <= (r_face == 2'(NUM_FACES - 1));
            o_degenerate <= (r_maxl == 7'd0);
            o_normal_x   <= (r_maxl == 7'd0) ? 32'd0 : (r_neg[0] ? -r_q[0] : r_q[0]);
            o_normal_y   <= (r_maxl == 7'd0) ? 32'd0 : (r_neg[1] ? -r_q[1] : r_q[1]);
            o_normal_z   <= (r_maxl == 7'd0) ? 32'd0 : (r_neg[2] ? -r_q[2] : r_q[2]);
        end
    end

    `OFN_ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != t_IDLE, o_stall)
    `OFN_ASSERT_IMPL(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `OFN_ASSERT_NEXT(a_start_on_final, i_clk, i_rst_n,
        r_state == t_IDLE && w_in_acc && i_final_vertex, r_state == t_LOADV)
    `OFN_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate,
        o_normal_x == 32'd0 && o_normal_y == 32'd0 && o_normal_z == 32'd0)
endmodule

>>> dv/octahedron_face_normals_test.sv
// Self-checking regression for the octahedron face normal unit.
module octahedron_face_normals_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES = 1500;

    // One expected normal beat, in the order the block emits them.
    typedef struct {
        logic [1:0]         face;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               degen;
        logic               last;
    } t_normal;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_vertex_index = '0;
    logic signed [31:0] i_vertex_x = '0;
    logic signed [31:0] i_vertex_y = '0;
    logic signed [31:0] i_vertex_z = '0;
    logic               i_final_vertex = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_face_index;
    logic signed [31:0] o_normal_x;
    logic signed [31:0] o_normal_y;
    logic signed [31:0] o_normal_z;
    logic               o_degenerate;
    logic               o_last_face;

    // Our own copy of the vertex store.
    logic signed [31:0] vtx_x [ofn_pkg::NUM_VERTICES];
    logic signed [31:0] vtx_y [ofn_pkg::NUM_VERTICES];
    logic signed [31:0] vtx_z [ofn_pkg::NUM_VERTICES];

    t_normal normal_queue[$];
    int      error_count = 0;
    int      burst_left = 0;
    int      stall_percent = 30;
    int      hold_off_left = 0;
    int      idle_cycles = 0;

    octahedron_face_normals DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_vertex_z     (i_vertex_z),
        .i_final_vertex (i_final_vertex),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_face_index   (o_face_index),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_degenerate   (o_degenerate),
        .o_last_face    (o_last_face)
    );

    always #5 i_clk = ~i_clk;

    // Integer square root, rounded down, by the classic digit-by-digit method.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = '0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Exact cross product a x b, scaled so that the largest magnitude has 31 bits,
    // then divided by its length with rounding to give a Q1.30 unit vector.
    function automatic t_normal unit_cross(input longint a [3], input longint b [3],
                                           input int face);
        logic signed [67:0] ax [3];
        logic signed [67:0] bx [3];
        logic signed [67:0] c [3];
        logic [67:0]        mag [3];
        logic [63:0]        m [3];
        logic [63:0]        len;
        logic [63:0]        q;
        logic [31:0]        r [3];
        int                 maxl;
        t_normal            n;
        for (int i = 0; i < 3; i++) begin
            ax[i] = a[i];
            bx[i] = b[i];
        end
        c[0] = ax[1] * bx[2] - ax[2] * bx[1];
        c[1] = ax[2] * bx[0] - ax[0] * bx[2];
        c[2] = ax[0] * bx[1] - ax[1] * bx[0];
        maxl = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (c[i] < 0) ? -c[i] : c[i];
            for (int k = 0; k < 68; k++) if (mag[i][k] && k + 1 > maxl) maxl = k + 1;
        end
        n.face = 2'(face);
        n.last = (face == ofn_pkg::NUM_FACES - 1);
        if (maxl == 0) begin
            n.nx = '0;
            n.ny = '0;
            n.nz = '0;
            n.degen = 1'b1;
            return n;
        end
        for (int i = 0; i < 3; i++) begin
            if (maxl > 31) m[i] = 64'(mag[i] >> (maxl - 31));
            else m[i] = 64'(mag[i] << (31 - maxl));
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            r[i] = (c[i] < 0) ? 32'(-q) : 32'(q);
        end
        n.nx = r[0];
        n.ny = r[1];
        n.nz = r[2];
        n.degen = 1'b0;
        return n;
    endfunction

    // Store an accepted vertex and, on a final beat, queue the four normals.
    task automatic load_vertex(input logic [2:0] idx, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z,
                               input logic fin);
        longint v [6][3];
        longint e0 [3], e1 [3], e2 [3], e4 [3], e6 [3], e7 [3];
        if (idx < ofn_pkg::NUM_VERTICES) begin
            vtx_x[idx] = x;
            vtx_y[idx] = y;
            vtx_z[idx] = z;
        end
        if (!fin) return;
        for (int i = 0; i < 6; i++) begin
            v[i][0] = vtx_x[i];
            v[i][1] = vtx_y[i];
            v[i][2] = vtx_z[i];
        end
        for (int k = 0; k < 3; k++) begin
            e0[k] = v[1][k] - v[0][k];
            e1[k] = v[3][k] - v[0][k];
            e2[k] = v[4][k] - v[0][k];
            e4[k] = v[4][k] - v[2][k];
            e6[k] = v[1][k] - v[2][k];
            e7[k] = v[3][k] - v[2][k];
        end
        normal_queue.push_back(unit_cross(e0, e2, 0));
        normal_queue.push_back(unit_cross(e1, e2, 1));
        normal_queue.push_back(unit_cross(e6, e4, 2));
        normal_queue.push_back(unit_cross(e7, e4, 3));
    endtask

    // Offer one vertex beat. The sender runs in bursts; between bursts valid drops for
    // a random pause. Valid stays high after the beat, so a burst runs back to back.
    task automatic send_vertex(input logic [2:0] idx, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z,
                               input logic fin);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_vertex_index <= idx;
        i_vertex_x     <= x;
        i_vertex_y     <= y;
        i_vertex_z     <= z;
        i_final_vertex <= fin;
        do @(posedge i_clk); while (o_stall);
        load_vertex(idx, x, y, z, fin);
    endtask

    task automatic wait_for_normals();
        i_valid <= 1'b0;
        burst_left = 0;
        while (normal_queue.size() != 0) @(posedge i_clk);
    endtask

    // Mostly full-range values, with small values and the extremes mixed in.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom;
            3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            4: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'h0;
        endcase
    endfunction

    // Load all six vertices in a random order, the last beat final. Some objects
    // collapse an edge or place all vertices on one line to make faces degenerate.
    task automatic send_object();
        logic [31:0] cx [6], cy [6], cz [6];
        int          order [6];
        int          j, tmp;
        for (int i = 0; i < 6; i++) begin
            cx[i] = pick_coord();
            cy[i] = pick_coord();
            cz[i] = pick_coord();
            order[i] = i;
        end
        case ($urandom_range(0, 7))
            0: begin
                cx[1] = cx[0];
                cy[1] = cy[0];
                cz[1] = cz[0];
            end
            1: begin
                for (int i = 0; i < 6; i++) begin
                    cy[i] = cx[i];
                    cz[i] = cx[i];
                end
            end
            default: ;
        endcase
        for (int i = 5; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 6; i++)
            send_vertex(3'(order[i]), cx[order[i]], cy[order[i]], cz[order[i]], i == 5);
    endtask

    // Directed corners: zero object, extreme coordinates, out-of-range indices,
    // a final beat on an ignored slot and a plain unit octahedron.
    task automatic test_directed();
        stall_percent = 0;
        for (int i = 0; i < 6; i++) send_vertex(3'(i), '0, '0, '0, i == 5);
        send_vertex(3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(3'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(3'd2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_vertex(3'd3, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_vertex(3'd4, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_vertex(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_vertex(3'd7, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 1'b0);
        send_vertex(3'd0, 32'h0001_0000, '0, '0, 1'b0);
        send_vertex(3'd1, 32'hffff_0000, '0, '0, 1'b0);
        send_vertex(3'd2, '0, 32'h0001_0000, '0, 1'b0);
        send_vertex(3'd3, '0, 32'hffff_0000, '0, 1'b0);
        send_vertex(3'd4, '0, '0, 32'h0001_0000, 1'b0);
        send_vertex(3'd5, '0, '0, 32'hffff_0000, 1'b1);
        send_vertex(3'd5, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        wait_for_normals();
    endtask

    // Well-formed objects with random content, salted with stray beats: repeated
    // final beats, out-of-range indices and lone reloads of a single slot.
    task automatic test_random_objects(input int objects);
        for (int n = 0; n < objects; n++) begin
            stall_percent = (n % 8 < 2) ? 0 : $urandom_range(10, 70);
            send_object();
            if ($urandom_range(0, 3) == 0)
                send_vertex(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                            1'($urandom_range(0, 1)));
        end
    endtask

    // The receiver holds off for a long stretch while objects keep arriving, so
    // that the block fills up and stalls the vertex channel.
    task automatic test_backpressure();
        hold_off_left = HOLD_OFF_CYCLES;
        for (int n = 0; n < 3; n++) send_object();
    endtask

    // The sender pauses until every normal has come out, then resumes.
    task automatic test_drain_pause();
        send_object();
        wait_for_normals();
        send_object();
        wait_for_normals();
    endtask

    // Receiver stall pattern, overridden by the long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_percent);
        end
    end

    // Compare every accepted normal beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_normal exp_n;
        if (i_rst_n && o_valid && !i_stall) begin
            if (normal_queue.size() == 0) begin
                $error("normal beat with nothing expected: face %0d", o_face_index);
                error_count++;
            end else begin
                exp_n = normal_queue.pop_front();
                if (o_face_index !== exp_n.face) begin
                    $error("face_index expected %0d got %0d", exp_n.face, o_face_index);
                    error_count++;
                end
                if (o_normal_x !== exp_n.nx) begin
                    $error("normal_x expected %0d got %0d", exp_n.nx, o_normal_x);
                    error_count++;
                end
                if (o_normal_y !== exp_n.ny) begin
                    $error("normal_y expected %0d got %0d", exp_n.ny, o_normal_y);
                    error_count++;
                end
                if (o_normal_z !== exp_n.nz) begin
                    $error("normal_z expected %0d got %0d", exp_n.nz, o_normal_z);
                    error_count++;
                end
                if (o_degenerate !== exp_n.degen) begin
                    $error("degenerate expected %0d got %0d", exp_n.degen, o_degenerate);
                    error_count++;
                end
                if (o_last_face !== exp_n.last) begin
                    $error("last_face expected %0d got %0d", exp_n.last, o_last_face);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any accepted beat on either channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_objects(16);
        test_backpressure();
        test_drain_pause();
        test_random_objects(16);
        wait_for_normals();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
